>>> src/lwpd_pkg.sv
package lwpd_pkg;

   localparam int WORD_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int NIB_W      = 4;
   localparam int PAL_DEPTH  = 16;
   localparam int IDX_W      = 4;
   localparam int SCREEN_BIT = 15;
   localparam int OFFSET_HI  = 14;
   localparam int OFFSET_LO  = 8;
   // offsets below 16 address green: bits 14..12 of the word are zero
   localparam int GREEN_HI   = 14;
   localparam int GREEN_LO   = 12;
   localparam int RSP_W      = 6 * BYTE_W;

   typedef logic [NIB_W-1:0]  nibble_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // palette write request
   typedef struct packed {
      logic     en;
      logic     green;
      idx_type  idx;
      byte_type value;
   } pal_wr_type;

   // palette read request, both pixels of a screen byte
   typedef struct packed {
      logic    en;
      idx_type left_idx;
      idx_type right_idx;
   } pal_rd_type;

   typedef struct packed {
      nibble_type red;
      nibble_type green;
      nibble_type blue;
   } rgb4_type;

   typedef struct packed {
      rgb4_type left;
      rgb4_type right;
   } pix_pair_type;

   function automatic byte_type widen_nibble(nibble_type n);
      return {n, n};
   endfunction

endpackage

>>> src/lwpd_palette.sv
module lwpd_palette (
   input  logic                  clock,
   input  logic                  reset,
   input  lwpd_pkg::pal_wr_type   wr,
   input  lwpd_pkg::pal_rd_type   rd,
   output lwpd_pkg::pix_pair_type rd_data
);
   import lwpd_pkg::*;

   // green store, and red/blue store as {blue, red}
   nibble_type                  green_mem_ff [PAL_DEPTH];
   logic [2*NIB_W-1:0]          rb_mem_ff    [PAL_DEPTH];
   logic [PAL_DEPTH-1:0]        green_vld_ff, green_vld_in;
   logic [PAL_DEPTH-1:0]        rb_vld_ff, rb_vld_in;
   pix_pair_type                rd_data_ff;

   always_comb begin
      green_vld_in = green_vld_ff;
      rb_vld_in    = rb_vld_ff;
      if (wr.en) begin
         if (wr.green) begin
            green_vld_in[wr.idx] = 1'b1;
         end else begin
            rb_vld_in[wr.idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         green_vld_ff <= '0;
         rb_vld_ff    <= '0;
      end else begin
         green_vld_ff <= green_vld_in;
         rb_vld_ff    <= rb_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         if (wr.green) begin
            green_mem_ff[wr.idx] <= wr.value[NIB_W-1:0];
         end else begin
            rb_mem_ff[wr.idx] <= wr.value;
         end
      end
   end

   // two read ports, data registered; an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff.left.green  <= green_vld_ff[rd.left_idx] ?
                                   green_mem_ff[rd.left_idx] : '0;
         rd_data_ff.left.red    <= rb_vld_ff[rd.left_idx] ?
                                   rb_mem_ff[rd.left_idx][NIB_W-1:0] : '0;
         rd_data_ff.left.blue   <= rb_vld_ff[rd.left_idx] ?
                                   rb_mem_ff[rd.left_idx][2*NIB_W-1:NIB_W] : '0;
         rd_data_ff.right.green <= green_vld_ff[rd.right_idx] ?
                                   green_mem_ff[rd.right_idx] : '0;
         rd_data_ff.right.red   <= rb_vld_ff[rd.right_idx] ?
                                   rb_mem_ff[rd.right_idx][NIB_W-1:0] : '0;
         rd_data_ff.right.blue  <= rb_vld_ff[rd.right_idx] ?
                                   rb_mem_ff[rd.right_idx][2*NIB_W-1:NIB_W] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lwpd_out_stage.sv
module lwpd_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  lwpd_pkg::pix_pair_type     in_data,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [lwpd_pkg::RSP_W-1:0] rsp_tdata
);
   import lwpd_pkg::*;

   logic                out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]    out_data_ff;
   logic                load;

   assign in_ready     = !out_valid_ff || rsp_tready;
   assign load         = in_valid && in_ready;
   assign out_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // left_red lowest, right_blue highest
   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= {widen_nibble(in_data.right.blue),
                         widen_nibble(in_data.right.green),
                         widen_nibble(in_data.right.red),
                         widen_nibble(in_data.left.blue),
                         widen_nibble(in_data.left.green),
                         widen_nibble(in_data.left.red)};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> src/line_word_palette_decoder_top.sv
// Line-word palette decoder. Takes one 16-bit line-buffer word per cycle on
// req_ while rsp_ is not back-pressured. A word with bit 15 set is a screen
// byte (bits 7..0): its high nibble indexes the left pixel and its low nibble
// the right pixel in a 16-entry palette of 4-bit red, green and blue, and one
// result word carrying both pixels as 8-bit RGB (each nibble replicated)
// leaves on rsp_. A word with bit 15 clear writes the palette and gives no
// result: offset (bits 14..8) below 16 loads green of that entry from the
// value's low nibble, any other offset loads entry offset&15 with red from the
// low and blue from the high nibble. The palette is all zero after reset. A
// screen word's result passes the registered palette read and then the output
// register before it is offered on rsp_. The palette write of a word is seen
// by every later screen word.
module line_word_palette_decoder_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [lwpd_pkg::WORD_W-1:0] req_tdata,  // [15:0] line_word
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [7:0] left_red, [15:8] left_green, [23:16] left_blue,
   // [31:24] right_red, [39:32] right_green, [47:40] right_blue
   output logic [lwpd_pkg::RSP_W-1:0] rsp_tdata
);
   import lwpd_pkg::*;

   logic          accept;
   logic          is_screen;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_ready;
   pal_wr_type    pal_wr;
   pal_rd_type    pal_rd;
   pix_pair_type  pal_data;

   // read stage holds while the output register is full and not being taken
   assign req_tready = !s1_valid_ff || s1_ready;
   assign accept     = req_tvalid && req_tready;
   assign is_screen  = req_tdata[SCREEN_BIT];

   // register write decode
   always_comb begin
      pal_wr.en    = accept && !is_screen;
      pal_wr.green = (req_tdata[GREEN_HI:GREEN_LO] == '0);
      pal_wr.idx   = req_tdata[OFFSET_LO+IDX_W-1:OFFSET_LO];
      pal_wr.value = req_tdata[BYTE_W-1:0];
   end

   // screen byte: two palette lookups
   always_comb begin
      pal_rd.en        = accept && is_screen;
      pal_rd.left_idx  = req_tdata[2*NIB_W-1:NIB_W];
      pal_rd.right_idx = req_tdata[NIB_W-1:0];
   end

   // valid for the registered read data
   assign s1_valid_in = pal_rd.en ? 1'b1 : (s1_ready ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   lwpd_palette u_palette (
      .clock   (clock),
      .reset   (reset),
      .wr      (pal_wr),
      .rd      (pal_rd),
      .rd_data (pal_data)
   );

   lwpd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_ready   (s1_ready),
      .in_data    (pal_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
